/* rtl/gtls_pkg.sv */
`default_nettype none
package gtls_pkg;

  localparam int unsigned MAX_LIGHTS  = 8;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned PHASE_W     = 3;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned COLORS_W    = 2 * MAX_LIGHTS;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = MASK_W * MAX_LIGHTS;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE          = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_DURATION  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_YELLOW_LEN      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_MASKS     = 8'd3;

  typedef enum logic [1:0] {
    COLOR_UNKNOWN = 2'd0,
    COLOR_RED     = 2'd1,
    COLOR_YELLOW  = 2'd2,
    COLOR_GREEN   = 2'd3
  } color_t;

  typedef struct packed {
    logic               found;
    logic               any_group;
    logic [PHASE_W-1:0] next;
  } search_t;

endpackage
`default_nettype wire

/* rtl/gtls_group_search.sv */
`default_nettype none
module gtls_group_search #(
  parameter int unsigned NUM_GROUPS = 8,
  parameter int unsigned NUM_LIGHTS = 8
) (
  input  wire logic [gtls_pkg::CFG_DATA_W-1:0] masks,
  input  wire logic [gtls_pkg::PHASE_W-1:0]    phase,
  output gtls_pkg::search_t                    result
);

  logic [NUM_GROUPS-1:0]        nonempty;
  logic [gtls_pkg::PHASE_W:0]   cand;

  always_comb begin
    nonempty = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int k = 0; k < NUM_LIGHTS; k++) begin
        if (masks[gtls_pkg::MASK_W * k + g]) begin
          nonempty[g] = 1'b1;
        end
      end
    end
  end

  // scan from the highest offset down so the nearest group after phase wins
  always_comb begin
    result.found     = 1'b0;
    result.any_group = |nonempty;
    result.next      = '0;
    cand             = '0;
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      cand = {1'b0, phase} + (gtls_pkg::PHASE_W+1)'(i + 1);
      if (cand >= (gtls_pkg::PHASE_W+1)'(NUM_GROUPS)) begin
        cand = cand - (gtls_pkg::PHASE_W+1)'(NUM_GROUPS);
      end
      if (nonempty[cand[gtls_pkg::PHASE_W-1:0]]) begin
        result.found = 1'b1;
        result.next  = cand[gtls_pkg::PHASE_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/grouped_traffic_light_sequencer_top.sv */
`default_nettype none
// Grouped traffic light sequencer. One timestamp item is taken per clock while
// in_stall is low and, while enabled, yields one colour report per item: the
// item is held in an input register, then the 34-bit elapsed-time compares, the
// round-robin group search and the colour update run in one pass into the
// result register. With enable low an item is consumed and no report is
// produced. A waiting report does not block the next item: the input
// register keeps accepting until both it and the result register are full.
module grouped_traffic_light_sequencer_top #(
  parameter int unsigned NUM_GROUPS = 8,
  parameter int unsigned NUM_LIGHTS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [gtls_pkg::TICK_W-1:0]        now_ticks,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [gtls_pkg::COLORS_W-1:0]           light_colors,
  output logic [gtls_pkg::PHASE_W-1:0]            active_phase,
  output logic                                    no_group_error,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gtls_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [gtls_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                              enable;
  logic [gtls_pkg::TICK_W-1:0]       phase_duration;
  logic [gtls_pkg::TICK_W-1:0]       yellow_len;
  logic [gtls_pkg::CFG_DATA_W-1:0]   light_group_masks;

  logic [gtls_pkg::PHASE_W-1:0]      phase;
  logic [gtls_pkg::PHASE_W-1:0]      phase_next;
  logic [gtls_pkg::TICK_W-1:0]       last_switch_time;
  logic                              yellow_pending;
  gtls_pkg::color_t                  colors [NUM_LIGHTS];
  gtls_pkg::color_t                  colors_next [NUM_LIGHTS];

  logic                              s1_valid;
  logic [gtls_pkg::TICK_W-1:0]       s1_ticks;
  logic                              s1_fire;
  logic                              step;

  logic [gtls_pkg::TICK_W-1:0]       elapsed;
  logic [gtls_pkg::TICK_W+1:0]       e2;
  logic [gtls_pkg::TICK_W+1:0]       d2;
  logic [gtls_pkg::TICK_W+1:0]       y_ext;
  logic                              yellow_hit;
  logic                              switch_hit;
  logic                              err;
  logic [gtls_pkg::COLORS_W-1:0]     colors_packed;
  logic [gtls_pkg::MASK_W-1:0]       lmask [NUM_LIGHTS];
  gtls_pkg::search_t                 srch;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable            <= 1'b0;
      phase_duration    <= '0;
      yellow_len        <= '0;
      light_group_masks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gtls_pkg::CFG_ENABLE:          enable            <= cfg_data[0];
        gtls_pkg::CFG_PHASE_DURATION:  phase_duration    <= cfg_data[gtls_pkg::TICK_W-1:0];
        gtls_pkg::CFG_YELLOW_LEN:      yellow_len        <= cfg_data[gtls_pkg::TICK_W-1:0];
        gtls_pkg::CFG_GROUP_MASKS:     light_group_masks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign step     = s1_fire && enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ticks <= now_ticks;
    end
  end

  gtls_group_search #(
    .NUM_GROUPS (NUM_GROUPS),
    .NUM_LIGHTS (NUM_LIGHTS)
  ) u_search (
    .masks  (light_group_masks),
    .phase  (phase),
    .result (srch)
  );

  assign elapsed    = s1_ticks - last_switch_time;
  assign e2         = {1'b0, elapsed, 1'b0};
  assign d2         = {1'b0, phase_duration, 1'b0};
  assign y_ext      = {2'b00, yellow_len};
  assign yellow_hit = (e2 + y_ext > d2) && (yellow_len != '0) && !yellow_pending;
  assign switch_hit = e2 > d2 + y_ext;
  assign err        = (yellow_hit || switch_hit) && !srch.found;

  always_comb begin
    for (int k = 0; k < NUM_LIGHTS; k++) begin
      lmask[k] = light_group_masks[gtls_pkg::MASK_W * k +: gtls_pkg::MASK_W];
    end
  end

  always_comb begin
    phase_next = phase;
    for (int k = 0; k < NUM_LIGHTS; k++) begin
      colors_next[k] = colors[k];
    end
    if (yellow_hit && srch.found) begin
      for (int k = 0; k < NUM_LIGHTS; k++) begin
        if (lmask[k][phase] && !lmask[k][srch.next]) begin
          colors_next[k] = gtls_pkg::COLOR_YELLOW;
        end
      end
    end
    if (switch_hit && srch.found) begin
      phase_next = srch.next;
      for (int k = 0; k < NUM_LIGHTS; k++) begin
        colors_next[k] = lmask[k][srch.next] ? gtls_pkg::COLOR_GREEN : gtls_pkg::COLOR_RED;
      end
    end
  end

  always_comb begin
    colors_packed = '0;
    for (int k = 0; k < NUM_LIGHTS; k++) begin
      colors_packed[2*k +: 2] = colors_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= '0;
      last_switch_time <= '0;
      yellow_pending   <= 1'b0;
      for (int k = 0; k < NUM_LIGHTS; k++) begin
        colors[k] <= gtls_pkg::COLOR_UNKNOWN;
      end
    end else if (step) begin
      phase <= phase_next;
      for (int k = 0; k < NUM_LIGHTS; k++) begin
        colors[k] <= colors_next[k];
      end
      if (switch_hit) begin
        yellow_pending   <= 1'b0;
        last_switch_time <= s1_ticks;
      end else if (yellow_hit) begin
        yellow_pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid && enable;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      light_colors   <= colors_packed;
      active_phase   <= phase_next;
      no_group_error <= err;
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, active_phase} < (gtls_pkg::PHASE_W+1)'(NUM_GROUPS)))
    else $error("reported phase outside the group range");

  a_unused_lights_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((light_colors >> (2 * NUM_LIGHTS)) == '0))
    else $error("colour reported for a light that does not exist");

  a_error_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    step && err |=> out_valid && no_group_error && $stable(phase))
    else $error("group error without its report or with a phase change");

  a_search_consistent: assert property (@(posedge clk) disable iff (rst)
    srch.found == srch.any_group)
    else $error("group search disagrees with group occupancy");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire

/* tb/light_report_monitor.sv */
`timescale 1ns / 1ps
module light_report_monitor #(
  parameter int unsigned NUM_GROUPS = 8,
  parameter int unsigned NUM_LIGHTS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic [gtls_pkg::TICK_W-1:0]      now_ticks,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [gtls_pkg::COLORS_W-1:0]    light_colors,
  input  wire logic [gtls_pkg::PHASE_W-1:0]     active_phase,
  input  wire logic                             no_group_error,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [gtls_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [gtls_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    reports_checked
);

  typedef struct packed {
    logic [gtls_pkg::COLORS_W-1:0] colors;
    logic [gtls_pkg::PHASE_W-1:0]  phase;
    logic                          no_group;
  } report_t;

  logic                            enabled      = 1'b0;
  logic [gtls_pkg::TICK_W-1:0]     phase_ticks  = '0;
  logic [gtls_pkg::TICK_W-1:0]     yellow_ticks = '0;
  logic [gtls_pkg::CFG_DATA_W-1:0] group_masks  = '0;

  logic [gtls_pkg::PHASE_W-1:0]    cur_phase    = '0;
  logic [gtls_pkg::TICK_W-1:0]     last_switch  = '0;
  logic                            yellow_armed = 1'b0;
  gtls_pkg::color_t                lamp [gtls_pkg::MAX_LIGHTS] =
                                     '{default: gtls_pkg::COLOR_UNKNOWN};

  report_t expected_reports [$];

  function automatic logic light_in_group(int unsigned k,
                                          logic [gtls_pkg::PHASE_W-1:0] g);
    return group_masks[gtls_pkg::MASK_W * k + g];
  endfunction

  // round-robin search starting after the current phase
  function automatic gtls_pkg::search_t next_group();
    int unsigned       cand;
    gtls_pkg::search_t res;
    res = '0;
    for (int unsigned i = 0; i < NUM_GROUPS; i++) begin
      cand = (cur_phase + 1 + i) % NUM_GROUPS;
      for (int unsigned k = 0; k < NUM_LIGHTS; k++) begin
        if (!res.found && light_in_group(k, cand[gtls_pkg::PHASE_W-1:0])) begin
          res.found     = 1'b1;
          res.any_group = 1'b1;
          res.next      = cand[gtls_pkg::PHASE_W-1:0];
        end
      end
    end
    return res;
  endfunction

  function automatic report_t advance_lights(logic [gtls_pkg::TICK_W-1:0] now);
    logic [gtls_pkg::TICK_W-1:0] elapsed;
    longint                      twice_e;
    longint                      twice_d;
    longint                      ylw;
    gtls_pkg::search_t           hit;
    report_t                     rep;
    rep     = '0;
    elapsed = now - last_switch;
    twice_e = 2 * longint'({32'd0, elapsed});
    twice_d = 2 * longint'({32'd0, phase_ticks});
    ylw     = longint'({32'd0, yellow_ticks});
    if (twice_e > twice_d - ylw && ylw > 0 && !yellow_armed) begin
      yellow_armed = 1'b1;
      hit = next_group();
      if (hit.found) begin
        for (int unsigned k = 0; k < NUM_LIGHTS; k++)
          if (light_in_group(k, cur_phase) && !light_in_group(k, hit.next))
            lamp[k] = gtls_pkg::COLOR_YELLOW;
      end else begin
        rep.no_group = 1'b1;
      end
    end
    if (twice_e > twice_d + ylw) begin
      yellow_armed = 1'b0;
      last_switch  = now;
      hit = next_group();
      if (hit.found) begin
        cur_phase = hit.next;
        for (int unsigned k = 0; k < NUM_LIGHTS; k++)
          lamp[k] = light_in_group(k, cur_phase) ? gtls_pkg::COLOR_GREEN
                                                 : gtls_pkg::COLOR_RED;
      end else begin
        rep.no_group = 1'b1;
      end
    end
    for (int unsigned k = 0; k < NUM_LIGHTS; k++)
      rep.colors[2*k +: 2] = lamp[k];
    rep.phase = cur_phase;
    return rep;
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gtls_pkg::CFG_ENABLE:         enabled      = cfg_data[0];
          gtls_pkg::CFG_PHASE_DURATION: phase_ticks  = cfg_data[gtls_pkg::TICK_W-1:0];
          gtls_pkg::CFG_YELLOW_LEN:     yellow_ticks = cfg_data[gtls_pkg::TICK_W-1:0];
          gtls_pkg::CFG_GROUP_MASKS:    group_masks  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {light_colors, active_phase, no_group_error};
        if (expected_reports.size() == 0) begin
          $error("unexpected report: light_colors %h active_phase %0d no_group_error %b",
                 light_colors, active_phase, no_group_error);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          if (got.colors !== want.colors) begin
            $error("light_colors: expected %h, got %h", want.colors, got.colors);
            fail_count++;
          end
          if (got.phase !== want.phase) begin
            $error("active_phase: expected %0d, got %0d", want.phase, got.phase);
            fail_count++;
          end
          if (got.no_group !== want.no_group) begin
            $error("no_group_error: expected %b, got %b", want.no_group, got.no_group);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall && enabled)
        expected_reports.insert(expected_reports.size(), advance_lights(now_ticks));
    end
    pending <= expected_reports.size();
  end

endmodule

/* tb/grouped_traffic_light_sequencer_top_tb.sv */
`timescale 1ns / 1ps
module grouped_traffic_light_sequencer_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 850;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam logic [gtls_pkg::CFG_INDEX_W-1:0] CFG_NO_SUCH_REG = 8'hFF;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  logic [gtls_pkg::TICK_W-1:0]      now_ticks = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [gtls_pkg::COLORS_W-1:0]    light_colors;
  logic [gtls_pkg::PHASE_W-1:0]     active_phase;
  logic                             no_group_error;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [gtls_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [gtls_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  int                               fail_count;
  int                               pending;
  int                               reports_checked;

  int unsigned                      idle_cycles   = 0;
  int unsigned                      stall_count   = 0;
  stall_mode_t                      stall_mode    = STALL_NONE;
  bit                               gaps_on       = 1'b0;
  int unsigned                      burst_left    = 0;
  logic [gtls_pkg::TICK_W-1:0]      tick_now      = '0;
  int unsigned                      ticks_sent    = 0;
  int unsigned                      settings_used = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  grouped_traffic_light_sequencer_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .now_ticks      (now_ticks),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .light_colors   (light_colors),
    .active_phase   (active_phase),
    .no_group_error (no_group_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  light_report_monitor u_monitor (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .now_ticks       (now_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .light_colors    (light_colors),
    .active_phase    (active_phase),
    .no_group_error  (no_group_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .reports_checked (reports_checked)
  );

  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
      default:      out_stall <= (stall_count % 9) < 4;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [gtls_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gtls_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [gtls_pkg::CFG_DATA_W-1:0] en_word,
                                input logic [gtls_pkg::TICK_W-1:0] dur,
                                input logic [gtls_pkg::TICK_W-1:0] ylw,
                                input logic [gtls_pkg::CFG_DATA_W-1:0] masks);
    write_reg(gtls_pkg::CFG_GROUP_MASKS, masks);
    write_reg(gtls_pkg::CFG_PHASE_DURATION, {$urandom(), dur});
    write_reg(gtls_pkg::CFG_YELLOW_LEN, {$urandom(), ylw});
    write_reg(gtls_pkg::CFG_ENABLE, en_word);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_tick(input logic [gtls_pkg::TICK_W-1:0] t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    tick_now = t;
    in_valid  <= 1'b1;
    now_ticks <= t;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // let every report arrive, then cover items that produce none
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [gtls_pkg::CFG_DATA_W-1:0] en_word;
    logic [gtls_pkg::CFG_DATA_W-1:0] masks;
    logic [gtls_pkg::TICK_W-1:0]     dur;
    logic [gtls_pkg::TICK_W-1:0]     ylw;
    logic [gtls_pkg::TICK_W-1:0]     delta;
    int unsigned                     random_sent;
    int unsigned                     burst_items;

    random_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    gaps_on = 1'b1;
    stall_mode <= STALL_RANDOM;

    // still disabled from reset: ignore
    send_tick(32'h0000_0000);
    send_tick(32'hFFFF_FFFF);
    drain();

    // no group populated
    apply_settings('1, 32'd0, 32'd0, '0);
    send_tick(32'h0000_0000);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    drain();

    // one light per group, switch on every tick
    apply_settings(64'd1, 32'd0, 32'd0, 64'h8040_2010_0804_0201);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd2);
    drain();

    // sparse, overlapping groups with yellow
    apply_settings(64'd1, 32'd2, 32'd3, 64'h0000_0000_0028_0881);
    send_tick(32'd3);
    send_tick(32'd5);
    send_tick(32'd6);
    send_tick(32'd7);
    send_tick(32'd10);
    send_tick(32'd11);
    send_tick(32'd14);
    drain();

    // longest durations
    apply_settings(64'h1234_5678_9ABC_DEF1, '1, '1, '1);
    send_tick(32'd14);
    send_tick(32'd14 + 32'h8000_0000);
    send_tick(32'd13);
    drain();

    // yellow wider than the whole phase
    apply_settings(64'd1, 32'd1, 32'd5, 64'h0102_0408_1020_4080);
    send_tick(32'd14);
    send_tick(32'd17);
    send_tick(32'd18);
    drain();

    // unknown register, then disable with upper bits set
    write_reg(CFG_NO_SUCH_REG, {$urandom(), $urandom()});
    apply_settings(64'hFFFF_FFFF_FFFF_FFFE, 32'd0, 32'd0, '1);
    send_tick(32'd40);
    send_tick(32'd41);
    drain();

    gaps_on = 1'b0;
    stall_mode <= STALL_NONE;

    while (random_sent < RANDOM_ITEMS) begin
      en_word = {$urandom(), $urandom()};
      en_word[0] = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
        0:       dur = '0;
        1:       dur = '1;
        2:       dur = $urandom();
        default: dur = $urandom_range(0, 24);
      endcase
      case ($urandom_range(0, 9))
        0:       ylw = '0;
        1:       ylw = '1;
        2:       ylw = $urandom();
        3:       ylw = 2 * dur + $urandom_range(1, 6);
        default: ylw = $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 7))
        0:       masks = '0;
        1:       masks = '1;
        2:       masks = {$urandom(), $urandom()};
        default: masks = {$urandom(), $urandom()} & {$urandom(), $urandom()}
                         & {$urandom(), $urandom()};
      endcase
      apply_settings(en_word, dur, ylw, masks);

      burst_items = $urandom_range(60, 130);
      if (burst_items > RANDOM_ITEMS - random_sent)
        burst_items = RANDOM_ITEMS - random_sent;
      repeat (burst_items) begin
        case ($urandom_range(0, 19))
          0:       delta = $urandom();
          1:       delta = '0;
          2, 3:    delta = $urandom_range(0, 64);
          default: delta = $urandom_range(0, 6);
        endcase
        send_tick(tick_now + delta);
        random_sent++;
      end
      drain();

      gaps_on = ($urandom_range(0, 3) != 0);
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
    end

    $display("%0d timestamps sent under %0d register settings", ticks_sent, settings_used);
    $display("%0d colour reports checked, %0d mismatches", reports_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
